FILE: rtl/itpc_pkg.sv
// Shared types, symbol codes and precedence tables of the infix to postfix converter.
package itpc_pkg;

	localparam int SYM_W = 8;

	// ASCII values of the operator characters
	localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
	localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
	localparam logic [SYM_W-1:0] CH_POW  = 8'h5E;
	localparam logic [SYM_W-1:0] CH_LPAR = 8'h28;
	localparam logic [SYM_W-1:0] CH_RPAR = 8'h29;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_LPAR = 3'd5,
		OP_RPAR = 3'd6,
		OP_NONE = 3'd7
	} code_t;

	// precedences carry an offset of +1 so that "empty stack" is 0
	typedef logic [3:0] prec_t;

	typedef struct packed {
		logic ld_in;     // latch the accepted transfer
		logic emit_sym;  // emit the input symbol
		logic emit_top;  // emit the operator on top of the stack
		logic push;
		logic pop;
		logic set_drop;  // operator dropped on a full stack
		logic finish;    // close the run of results of this item
	} cmd_t;

	typedef struct packed {
		logic is_operand;
		logic gt;          // out-stack precedence above top's in-stack one
		logic eq;
		logic full;
		logic empty;
		logic top_paren;
		logic end_q;
		logic stall_emit;
		logic stall_fin;
	} status_t;

	function automatic code_t op_code(input logic [SYM_W-1:0] c);
		code_t r;
		case (c)
			CH_ADD:  r = OP_ADD;
			CH_SUB:  r = OP_SUB;
			CH_MUL:  r = OP_MUL;
			CH_DIV:  r = OP_DIV;
			CH_POW:  r = OP_POW;
			CH_LPAR: r = OP_LPAR;
			CH_RPAR: r = OP_RPAR;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [SYM_W-1:0] op_char(input code_t c);
		logic [SYM_W-1:0] r;
		case (c)
			OP_ADD:  r = CH_ADD;
			OP_SUB:  r = CH_SUB;
			OP_MUL:  r = CH_MUL;
			OP_DIV:  r = CH_DIV;
			OP_POW:  r = CH_POW;
			OP_LPAR: r = CH_LPAR;
			OP_RPAR: r = CH_RPAR;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic prec_t out_prec(input code_t c);
		prec_t r;
		case (c)
			OP_ADD, OP_SUB: r = 4'd2;
			OP_MUL, OP_DIV: r = 4'd4;
			OP_POW:         r = 4'd7;
			OP_LPAR:        r = 4'd8;
			OP_RPAR:        r = 4'd1;
			default:        r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic prec_t in_prec(input code_t c);
		prec_t r;
		case (c)
			OP_ADD, OP_SUB: r = 4'd3;
			OP_MUL, OP_DIV: r = 4'd5;
			OP_POW:         r = 4'd6;
			OP_LPAR:        r = 4'd1;
			default:        r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/itpc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module itpc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/itpc_ctrl.sv
// Sequencer of the infix to postfix converter: steps one item through compare, pop and flush.
module itpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  itpc_pkg::status_t st,
	output itpc_pkg::cmd_t    cmd
);
	import itpc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE        = 7'b0000001,
		S_DECIDE      = 7'b0000010,
		S_SETTLE_LOOP = 7'b0000100,
		S_SETTLE_DONE = 7'b0001000,
		S_FLUSH       = 7'b0010000,
		S_FLUSH_WAIT  = 7'b0100000,
		S_FINISH      = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_nx  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (st.is_operand) begin
					if (!st.stall_emit) begin
						cmd.emit_sym = 1'b1;
						state_nx     = st.end_q ? S_FLUSH : S_FINISH;
					end
				end else if (st.gt) begin
					if (st.full) begin
						cmd.set_drop = 1'b1;
					end else begin
						cmd.push = 1'b1;
					end
					state_nx = S_SETTLE_DONE;
				end else if (st.eq) begin
					cmd.pop  = 1'b1;
					state_nx = S_SETTLE_DONE;
				end else if (!st.stall_emit) begin
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					state_nx     = S_SETTLE_LOOP;
				end
			end
			S_SETTLE_LOOP: begin
				state_nx = S_DECIDE;
			end
			S_SETTLE_DONE: begin
				state_nx = st.end_q ? S_FLUSH : S_FINISH;
			end
			S_FLUSH: begin
				if (st.empty) begin
					state_nx = S_FINISH;
				end else if (st.top_paren) begin
					cmd.pop  = 1'b1;
					state_nx = S_FLUSH_WAIT;
				end else if (!st.stall_emit) begin
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					state_nx     = S_FLUSH_WAIT;
				end
			end
			S_FLUSH_WAIT: begin
				state_nx = S_FLUSH;
			end
			S_FINISH: begin
				if (!st.stall_fin) begin
					cmd.finish = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: rtl/itpc_dp.sv
// Datapath of the infix to postfix converter: input latch, operator stack, hold and output registers.
module itpc_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [itpc_pkg::SYM_W-1:0]    in_symbol,
	input  logic                          in_end,
	input  itpc_pkg::cmd_t                cmd,
	output itpc_pkg::status_t             st,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [itpc_pkg::SYM_W-1:0]    out_symbol,
	output logic                          out_sym_valid,
	output logic                          out_last,
	output logic                          out_done,
	output logic                          out_ovf
);
	import itpc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic [SYM_W-1:0] sym_q;
	logic             end_q;
	logic             drop_q;
	logic [CW-1:0]    count_q;
	logic [SYM_W-1:0] hold_sym_q;
	logic             hold_valid_q;
	logic             out_valid_q;

	code_t            in_code;
	code_t            top_code;
	logic [2:0]       top_raw;
	logic [CW-1:0]    count_dec;
	logic [IW-1:0]    rd_addr;
	prec_t            top_prec;
	logic             out_busy;
	logic             emit;
	logic [SYM_W-1:0] emit_sym;

	assign in_code   = op_code(sym_q);
	assign count_dec = count_q - 1'b1;
	// stack read always points at the current top; the registered read data follows a change in the cycle after it
	assign rd_addr   = (count_q == '0) ? '0 : count_dec[IW-1:0];

	itpc_ram #(
		.WIDTH(3),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(count_q[IW-1:0]),
		.wdata(in_code),
		.raddr(rd_addr),
		.rdata(top_raw)
	);

	assign top_code = code_t'(top_raw);
	assign top_prec = (count_q == '0) ? prec_t'(0) : in_prec(top_code);
	assign out_busy = out_valid_q && !m_tready;

	always_comb begin
		st            = '0;
		st.is_operand = (in_code == OP_NONE);
		st.gt         = out_prec(in_code) > top_prec;
		st.eq         = out_prec(in_code) == top_prec;
		st.full       = (count_q == CW'(STACK_DEPTH));
		st.empty      = (count_q == '0);
		st.top_paren  = (top_code == OP_LPAR) || (top_code == OP_RPAR);
		st.end_q      = end_q;
		st.stall_emit = hold_valid_q && out_busy;
		st.stall_fin  = (hold_valid_q || drop_q || end_q) && out_busy;
	end

	assign emit     = cmd.emit_sym || cmd.emit_top;
	assign emit_sym = cmd.emit_sym ? sym_q : op_char(top_code);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			drop_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_dec;
			end
			if (cmd.ld_in) begin
				drop_q <= 1'b0;
			end else if (cmd.set_drop) begin
				drop_q <= 1'b1;
			end
			if (emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end
			if ((emit && hold_valid_q) || (cmd.finish && (hold_valid_q || drop_q || end_q))) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			sym_q <= in_symbol;
			end_q <= in_end;
		end
		if (emit) begin
			hold_sym_q <= emit_sym;
		end
		if (emit && hold_valid_q) begin
			out_symbol    <= hold_sym_q;
			out_sym_valid <= 1'b1;
			out_last      <= 1'b0;
			out_done      <= 1'b0;
			out_ovf       <= drop_q;
		end else if (cmd.finish && (hold_valid_q || drop_q || end_q)) begin
			// a finish with nothing to show leaves a waiting result untouched
			out_symbol    <= hold_valid_q ? hold_sym_q : '0;
			out_sym_valid <= hold_valid_q;
			out_last      <= 1'b1;
			out_done      <= end_q;
			out_ovf       <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < CW'(STACK_DEPTH)))
		else $error("push on full stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop on empty stack");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && hold_valid_q) |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

endmodule

FILE: rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix to postfix converter: stream ports, sequencer and datapath.
//
// channel | dir | tdata               | tlast       | tuser (lsb up)
// s_*     | in  | [7:0] symbol        | expr. end   | -
// m_*     | out | [7:0] postfix_symbol| run_last    | symbol_valid, expression_done, overflow
//
// Steps: an operand passes accept, decide and finish; an operator that is pushed, dropped
//   or that cancels a '(' also passes a settle state. Each operator popped by comparison
//   adds an emit step and a settle step for the stack RAM's registered read to present the
//   new top. An expression end adds the flush's empty check plus a pop step and a settle
//   step per stack entry, parentheses included.
// One item is in work at a time; s_tready is high only while the sequencer is idle.
// A result waits in a hold register until the next one of the same item is known, so
//   run_last is set without lookahead; the output register parts it from m_tready.
// Stalls on m_tready freeze the sequencer only when a result must move into a full
//   output register.
// Reset clears the stack count, flags and valids; stack entries are never read before
//   they are written, so there is no clearing pass.
module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // expression_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] postfix_symbol
	output logic       m_tlast,   // run_last
	output logic [2:0] m_tuser    // [0] symbol_valid, [1] expression_done, [2] overflow_flag
);
	import itpc_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer: compare / pop / flush steps, one per state
	itpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	// datapath: input latch, operator stack RAM, hold and output registers
	itpc_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_symbol    (s_tdata),
		.in_end       (s_tlast),
		.cmd          (cmd),
		.st           (st),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_symbol   (m_tdata),
		.out_sym_valid(m_tuser[0]),
		.out_last     (m_tlast),
		.out_done     (m_tuser[1]),
		.out_ovf      (m_tuser[2])
	);

endmodule
